/* rtl/teq_pkg.sv */
// Shared types and constants for the timed event queue.
// Used by the cell, the core and the checker; depends on nothing else.
package teq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_REM_OWNER  = 3'd1,
    OP_REM_BOTH   = 3'd2,
    OP_FIND       = 3'd3,
    OP_POP_DUE    = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_CLEAR_TYPE = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    ACT_HOLD    = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_POP     = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_COMPACT = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    MATCH_OWNER = 2'd0,
    MATCH_BOTH  = 2'd1,
    MATCH_TYPE  = 2'd2
  } match_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] now;
    logic [23:0] delay;
    logic [15:0] owner_id;
    logic [3:0]  event_type;
    logic [15:0] payload;
  } in_t;

  typedef struct packed {
    logic        status;
    logic        found;
    logic        popped_valid;
    logic [15:0] popped_owner;
    logic [3:0]  popped_type;
    logic [15:0] popped_payload;
    logic [31:0] head_time;
    logic [6:0]  pending_count;
  } out_t;

  typedef struct packed {
    logic [31:0] fire;
    logic [3:0]  etype;
    logic [15:0] owner;
    logic [15:0] payload;
  } entry_t;

  typedef struct packed {
    act_e        act;
    match_e      mode;
    entry_t      key;
  } cell_ctrl_t;

endpackage

/* rtl/teq_cell.sv */
// One slot of the sorted queue: holds an entry and moves it to or from its neighbors.
// Depends on teq_pkg.
module teq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  teq_pkg::cell_ctrl_t ctrl,
  input  teq_pkg::entry_t   left_entry,
  input  logic              left_le,
  input  logic              left_valid,
  input  teq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  input  logic              hit_in,
  output teq_pkg::entry_t   entry,
  output logic              valid,
  output logic              le,
  output logic              hit_out
);
  import teq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   hit;

  assign le = valid_r && (entry_r.fire <= ctrl.key.fire);

  always_comb begin
    unique case (ctrl.mode)
      MATCH_OWNER: hit = entry_r.owner == ctrl.key.owner;
      MATCH_BOTH:  hit = (entry_r.owner == ctrl.key.owner) &&
                         (entry_r.etype == ctrl.key.etype);
      MATCH_TYPE:  hit = entry_r.etype == ctrl.key.etype;
      default:     hit = 1'b0;
    endcase
    hit = hit && valid_r;
  end

  // Any hit at or below this slot means the slot closes the lowest gap.
  assign hit_out = hit_in || hit;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (ctrl.act)
      ACT_INSERT: begin
        if (!le) begin
          if (left_le) begin
            entry_nxt = ctrl.key;
            valid_nxt = 1'b1;
          end else begin
            // An empty slot only fills when its left neighbor held an entry.
            entry_nxt = left_entry;
            valid_nxt = left_valid;
          end
        end
      end
      ACT_POP: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      ACT_CLEAR: valid_nxt = 1'b0;
      ACT_COMPACT: begin
        if (hit_out) begin
          entry_nxt = right_entry;
          valid_nxt = right_valid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

/* rtl/timed_event_queue_core.sv */
// Top level of the timed event queue: sequencer plus a row of teq_cell slots.
// Depends on teq_pkg and teq_cell.
//
// Usage: drive in_data and raise start; the command is taken at a clock edge where
// start is high and busy is low. busy stays high until the result has been shown.
// The result appears on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall it, so it must sample that cycle.
// Sequence: add, pop due, find, clear and unused codes pass through the update state
// (ST_EXEC) and then the result state (ST_RESP), in which the result strobe is shown.
// The removal commands stay in ST_EXEC and close one gap per cycle in the cell row
// until no matching event is left (up to QUEUE_DEPTH events), then go to ST_RESP.
// One command is in flight at a time; busy drops in the cycle after the result
// strobe and the next command may be accepted at the end of that cycle.
// The row compares every slot in parallel against the new fire time or the match
// key; a pop shifts the whole row by one slot, an insert only the later slots.
// Reset (synchronous) empties the queue (slot valid bits clear); slot contents are
// not reset and are never read while invalid.
module timed_event_queue_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  teq_pkg::in_t  in_data,
  output logic          out_valid,
  output teq_pkg::out_t out_data
);
  import teq_pkg::*;

  state_e state_r, state_nxt;
  in_t    cmd_r;
  logic [31:0] fire_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic   status_r, status_nxt;
  logic   found_r, found_nxt;
  logic   pv_r, pv_nxt;
  entry_t popped_r, popped_nxt;
  logic   stay;

  cell_ctrl_t ctrl;
  entry_t cell_entry [QUEUE_DEPTH];
  logic   cell_valid [QUEUE_DEPTH];
  logic   cell_le    [QUEUE_DEPTH];
  logic   cell_hit   [QUEUE_DEPTH];
  logic   any_hit;
  logic [32:0] sum;

  assign sum = {1'b0, in_data.now} + {9'd0, in_data.delay};
  assign any_hit = cell_hit[QUEUE_DEPTH-1];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t le_entry, ri_entry;
    logic   l_le, l_valid, r_valid, h_in;
    if (i == 0) begin : g_first
      assign le_entry = ctrl.key;
      assign l_le     = 1'b1;
      assign l_valid  = 1'b1;
      assign h_in     = 1'b0;
    end else begin : g_mid
      assign le_entry = cell_entry[i-1];
      assign l_le     = cell_le[i-1];
      assign l_valid  = cell_valid[i-1];
      assign h_in     = cell_hit[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign ri_entry = cell_entry[i];
      assign r_valid  = 1'b0;
    end else begin : g_inner
      assign ri_entry = cell_entry[i+1];
      assign r_valid  = cell_valid[i+1];
    end
    teq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_entry  (le_entry),
      .left_le     (l_le),
      .left_valid  (l_valid),
      .right_entry (ri_entry),
      .right_valid (r_valid),
      .hit_in      (h_in),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .le          (cell_le[i]),
      .hit_out     (cell_hit[i])
    );
  end

  // Cell control: the match key and the row action for this cycle.
  always_comb begin
    ctrl.key.fire    = fire_r;
    ctrl.key.etype   = cmd_r.event_type;
    ctrl.key.owner   = cmd_r.owner_id;
    ctrl.key.payload = cmd_r.payload;
    ctrl.act         = ACT_HOLD;
    case (op_e'(cmd_r.operation))
      OP_REM_OWNER:  ctrl.mode = MATCH_OWNER;
      OP_CLEAR_TYPE: ctrl.mode = MATCH_TYPE;
      default:       ctrl.mode = MATCH_BOTH;
    endcase
    stay       = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    pv_nxt     = pv_r;
    popped_nxt = popped_r;
    if (state_r == ST_IDLE) begin
      status_nxt = 1'b0;
      found_nxt  = 1'b0;
      pv_nxt     = 1'b0;
    end else if (state_r == ST_EXEC) begin
      unique case (op_e'(cmd_r.operation))
        OP_ADD: begin
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            status_nxt = 1'b1;
          end else begin
            ctrl.act  = ACT_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP_DUE: begin
          if (cell_valid[0] && (cmd_r.now >= cell_entry[0].fire)) begin
            ctrl.act   = ACT_POP;
            count_nxt  = count_r - 1'b1;
            pv_nxt     = 1'b1;
            popped_nxt = cell_entry[0];
          end
        end
        OP_CLEAR: begin
          ctrl.act  = ACT_CLEAR;
          count_nxt = '0;
        end
        OP_FIND: found_nxt = any_hit;
        OP_REM_OWNER, OP_REM_BOTH, OP_CLEAR_TYPE: begin
          if (any_hit) begin
            ctrl.act  = ACT_COMPACT;
            count_nxt = count_r - 1'b1;
            stay      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: if (!stay) state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      status_r <= 1'b0;
      found_r  <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      found_r  <= found_nxt;
      pv_r     <= pv_nxt;
    end
    popped_r <= popped_nxt;
    if (state_r == ST_IDLE && start) begin
      cmd_r  <= in_data;
      fire_r <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

  always_comb begin
    busy                    = state_r != ST_IDLE;
    out_valid               = state_r == ST_RESP;
    out_data.status         = status_r;
    out_data.found          = found_r;
    out_data.popped_valid   = pv_r;
    out_data.popped_owner   = pv_r ? popped_r.owner : 16'd0;
    out_data.popped_type    = pv_r ? popped_r.etype : 4'd0;
    out_data.popped_payload = pv_r ? popped_r.payload : 16'd0;
    out_data.head_time      = cell_valid[0] ? cell_entry[0].fire : 32'd0;
    out_data.pending_count  = 7'(count_r);
  end

endmodule

/* rtl/teq_checker.sv */
// Port-level checks for the timed event queue, bound to the top level.
// Depends on teq_pkg and timed_event_queue_core.
module teq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input teq_pkg::out_t out_data
);
  import teq_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pending_count == 7'd0) |-> out_data.head_time == 32'd0)
    else $error("empty queue reports a head time");

  a_pop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.popped_valid) |->
      (out_data.popped_owner == 16'd0 && out_data.popped_payload == 16'd0))
    else $error("popped fields set without a pop");

endmodule

bind timed_event_queue_core teq_checker u_teq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
